>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; clk and rst_n must be in scope at the use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`endif

`endif

>>> design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam logic [7:0] PHASE_TICKS_RESET = 8'd5;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_WRITE3 = 2'd1,
        ACT_WRITE2 = 2'd2,
        ACT_READ   = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        STEP_IDLE  = 3'd0,
        STEP_START = 3'd1,
        STEP_SEND  = 3'd2,
        STEP_RECV  = 3'd3,
        STEP_STOP  = 3'd4
    } step_t;

    typedef struct packed {
        step_t       step;
        logic [1:0]  quarter;
        logic [7:0]  tick;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [15:0] pending;
        act_t        kind;
        logic [1:0]  byte_count;
        logic        ack;
        logic [7:0]  rx_byte;
        logic        scl;
        logic        sda;
    } eng_state_t;

    // packed LSB first: scl, sda, busy, done, success, read_data
    typedef struct packed {
        logic [7:0] read_data;
        logic       success;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } result_t;

    localparam eng_state_t ENG_STATE_RESET = '{
        step: STEP_IDLE, quarter: 2'd0, tick: 8'd0, bit_index: 4'd0,
        shift_byte: 8'd0, pending: 16'd0, kind: ACT_TICK, byte_count: 2'd0,
        ack: 1'b0, rx_byte: 8'd0, scl: 1'b1, sda: 1'b1
    };

endpackage

>>> design/i2c_master_byte_transactions_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_transactions_unit
// Tick-driven single-master I2C engine: three-byte write, two-byte write and
// one-byte read, with a programmable quarter-bit phase length.
// Result of an item: registered with the sequencer step, valid in the cycle after accept.
// Throughput: one item per cycle unless the result output is stalled.
// Reset (rst_n low, asynchronous): engine idle, lines released, phase length 5.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_byte_transactions_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,        // ticks_per_phase
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // device_address, second_byte, third_byte, sda_in
    input  logic [1:0]  s_axis_tuser,    // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // scl_out, sda_out, busy_res, done_res, success,
                                         // read_data
);
    import i2cm_pkg::*;

    eng_state_t state_reg;
    eng_state_t state_next;
    result_t    result_reg;
    result_t    result_next;
    logic [7:0] phase_ticks_reg;
    logic       out_valid_reg;
    logic       accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, result_reg};

    i2cm_step u_step (
        .st             (state_reg),
        .phase_ticks    (phase_ticks_reg),
        .action         (s_axis_tuser),
        .device_address (s_axis_tdata[7:0]),
        .second_byte    (s_axis_tdata[15:8]),
        .third_byte     (s_axis_tdata[23:16]),
        .sda_in         (s_axis_tdata[24]),
        .st_next        (state_next),
        .res            (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ENG_STATE_RESET;
            phase_ticks_reg <= PHASE_TICKS_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                phase_ticks_reg <= cfg_data;
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    `ASSERT_IMPLIES(a_done_not_busy, out_valid_reg && result_reg.done, !result_reg.busy)
    `ASSERT_IMPLIES(a_success_with_done, out_valid_reg && result_reg.success, result_reg.done)
    `ASSERT_IMPLIES(a_idle_phase_clear, state_reg.step == STEP_IDLE, state_reg.tick == 8'd0 && state_reg.quarter == 2'd0)
    `ASSERT_ALWAYS(a_bit_index_range, state_reg.bit_index <= 4'(BITS_PER_BYTE))

endmodule

>>> design/i2cm_step.sv
// ----------------------------------------------------------------------------
// i2cm_step
// One tick of the bus sequencer: next engine state and the tick's result.
// ----------------------------------------------------------------------------
module i2cm_step (
    input  i2cm_pkg::eng_state_t st,
    input  logic [7:0]           phase_ticks,
    input  logic [1:0]           action,
    input  logic [7:0]           device_address,
    input  logic [7:0]           second_byte,
    input  logic [7:0]           third_byte,
    input  logic                 sda_in,
    output i2cm_pkg::eng_state_t st_next,
    output i2cm_pkg::result_t    res
);
    import i2cm_pkg::*;

    localparam logic [3:0] BIT_LAST = 4'(BITS_PER_BYTE);
    localparam logic [2:0] BIT_TOP  = 3'(BITS_PER_BYTE - 1);

    logic [7:0] tpp;
    logic [7:0] tc;
    logic       pulse;
    logic       done;
    logic       ok;
    eng_state_t nx;

    always_comb
    begin
        nx    = st;
        done  = 1'b0;
        ok    = 1'b0;
        pulse = 1'b0;
        tc    = 8'd0;
        tpp   = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;

        if (st.step == STEP_IDLE && action != ACT_TICK)
        begin
            nx.kind       = act_t'(action);
            nx.shift_byte = (action == ACT_READ) ? device_address + 8'd1 : device_address;
            case (act_t'(action))
                ACT_WRITE3:
                begin
                    nx.pending    = {second_byte, third_byte};
                    nx.byte_count = 2'd2;
                end
                ACT_WRITE2:
                begin
                    nx.pending    = {second_byte, 8'd0};
                    nx.byte_count = 2'd1;
                end
                default:
                begin
                    nx.pending    = 16'd0;
                    nx.byte_count = 2'd0;
                end
            endcase
            nx.step      = STEP_START;
            nx.quarter   = 2'd0;
            nx.tick      = 8'd0;
            nx.bit_index = 4'd0;
            nx.ack       = 1'b0;
        end

        if (nx.step != STEP_IDLE)
        begin
            pulse = (nx.quarter == 2'd1) || (nx.quarter == 2'd2);
            case (nx.step)
                STEP_START:
                begin
                    if (nx.quarter != 2'd0)
                        nx.scl = (nx.quarter != 2'd3);
                    nx.sda = (nx.quarter < 2'd2);
                end
                STEP_SEND:
                begin
                    nx.scl = pulse;
                    if (nx.bit_index < BIT_LAST)
                        nx.sda = nx.shift_byte[BIT_TOP - nx.bit_index[2:0]];
                    else
                        nx.sda = 1'b1;
                end
                STEP_RECV:
                begin
                    nx.scl = pulse;
                    nx.sda = 1'b1;
                end
                default:
                begin
                    nx.scl = (nx.quarter != 2'd0);
                    nx.sda = (nx.quarter >= 2'd2);
                end
            endcase

            tc = nx.tick + 8'd1;
            if (tc >= tpp || tc == 8'd0)
            begin
                nx.tick = 8'd0;
                // sample at end of the second quarter
                if (nx.quarter == 2'd1)
                begin
                    if (nx.step == STEP_SEND && nx.bit_index >= BIT_LAST)
                        nx.ack = ~sda_in;
                    else if (nx.step == STEP_RECV && nx.bit_index < BIT_LAST)
                        nx.shift_byte = {nx.shift_byte[6:0], sda_in};
                end
                if (nx.quarter != 2'd3)
                begin
                    nx.quarter = nx.quarter + 2'd1;
                end
                else
                begin
                    nx.quarter = 2'd0;
                    case (nx.step)
                        STEP_START:
                        begin
                            nx.step      = STEP_SEND;
                            nx.bit_index = 4'd0;
                        end
                        STEP_SEND:
                        begin
                            if (nx.bit_index < BIT_LAST)
                            begin
                                nx.bit_index = nx.bit_index + 4'd1;
                            end
                            else if (!nx.ack)
                            begin
                                if (nx.kind == ACT_READ)
                                    nx.rx_byte = 8'd0;
                                nx.step = STEP_IDLE;
                                done    = 1'b1;
                            end
                            else if (nx.kind == ACT_READ)
                            begin
                                nx.step       = STEP_RECV;
                                nx.bit_index  = 4'd0;
                                nx.shift_byte = 8'd0;
                            end
                            else if (nx.byte_count != 2'd0)
                            begin
                                nx.shift_byte = nx.pending[15:8];
                                nx.pending    = {nx.pending[7:0], 8'd0};
                                nx.byte_count = nx.byte_count - 2'd1;
                                nx.bit_index  = 4'd0;
                            end
                            else
                            begin
                                nx.step = STEP_STOP;
                            end
                        end
                        STEP_RECV:
                        begin
                            if (nx.bit_index < BIT_LAST)
                            begin
                                nx.bit_index = nx.bit_index + 4'd1;
                            end
                            else
                            begin
                                nx.rx_byte = nx.shift_byte;
                                nx.step    = STEP_STOP;
                            end
                        end
                        default:
                        begin
                            nx.step = STEP_IDLE;
                            done    = 1'b1;
                            ok      = 1'b1;
                        end
                    endcase
                end
            end
            else
            begin
                nx.tick = tc;
            end
        end

        st_next       = nx;
        res.scl       = nx.scl;
        res.sda       = nx.sda;
        res.busy      = (nx.step != STEP_IDLE);
        res.done      = done;
        res.success   = ok;
        res.read_data = nx.rx_byte;
    end

endmodule

>>> verif/i2c_master_byte_transactions_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_transactions_unit_tb
// Tick-by-tick check of the I2C master byte engine. Every tick item sent in
// is run through a local model of the bus sequencer, and every result item
// is compared field by field with the oldest prediction. Stimulus plays the
// part of an I2C slave: ACK/NACK and read data are placed on the sample tick
// of each bit, the rest of the SDA ticks and all busy-time commands are noise.
// The phase length is changed between phases only, with the engine idle.
// ----------------------------------------------------------------------------
module i2c_master_byte_transactions_unit_tb;

    import i2cm_pkg::*;

    typedef struct {
        act_t       action;
        logic [7:0] addr;
        logic [7:0] second;
        logic [7:0] third;
        logic       sda;
    } tick_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // device_address, second_byte, third_byte, sda_in
    logic [1:0]  s_axis_tuser = ACT_TICK; // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // scl_out, sda_out, busy_res, done_res, success,
                                        // read_data

    i2c_master_byte_transactions_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // bus sequencer model state
    logic [7:0]  phase_len = PHASE_TICKS_RESET;
    step_t       m_step = STEP_IDLE;
    logic [1:0]  m_quarter = '0;
    logic [7:0]  m_ticks = '0;
    logic [3:0]  m_bit = '0;
    logic [7:0]  m_shift = '0;
    logic [15:0] m_pending = '0;
    act_t        m_kind = ACT_TICK;
    logic [1:0]  m_left = '0;
    logic        m_ack = 1'b0;
    logic [7:0]  m_rx = '0;
    logic        m_scl = 1'b1;
    logic        m_sda = 1'b1;

    tick_item_t  tick_q[$];
    result_t     bus_levels_due[$];
    tick_item_t  on_bus;
    bit          no_gaps = 1'b0;
    int          mismatches = 0;
    int          ticks_sent = 0;
    int          results_seen = 0;
    int          long_stall = 0;
    bit          stall_taken = 1'b0;
    int          n_writes = 0;
    int          n_reads = 0;
    int          n_aborts = 0;
    int          cfg_writes = 0;

    function automatic result_t next_bus_levels(tick_item_t it);
        result_t    r;
        logic [7:0] len;
        logic       pulse;
        r = '0;
        len = (phase_len == 8'd0) ? 8'd1 : phase_len;
        if (m_step == STEP_IDLE && it.action != ACT_TICK)
        begin
            m_kind = it.action;
            m_shift = (it.action == ACT_READ) ? it.addr + 8'd1 : it.addr;
            case (it.action)
                ACT_WRITE3:
                begin
                    m_pending = {it.second, it.third};
                    m_left = 2'd2;
                end
                ACT_WRITE2:
                begin
                    m_pending = {it.second, 8'd0};
                    m_left = 2'd1;
                end
                default:
                begin
                    m_pending = '0;
                    m_left = 2'd0;
                end
            endcase
            m_step = STEP_START;
            m_quarter = '0;
            m_ticks = '0;
            m_bit = '0;
            m_ack = 1'b0;
        end
        if (m_step != STEP_IDLE)
        begin
            pulse = (m_quarter == 2'd1 || m_quarter == 2'd2);
            case (m_step)
                STEP_START:
                begin
                    if (m_quarter != 2'd0)
                        m_scl = (m_quarter != 2'd3);
                    m_sda = (m_quarter < 2'd2);
                end
                STEP_SEND:
                begin
                    m_scl = pulse;
                    m_sda = (m_bit < BITS_PER_BYTE) ? m_shift[BITS_PER_BYTE - 1 - m_bit] : 1'b1;
                end
                STEP_RECV:
                begin
                    m_scl = pulse;
                    m_sda = 1'b1;
                end
                default:
                begin
                    m_scl = (m_quarter != 2'd0);
                    m_sda = (m_quarter >= 2'd2);
                end
            endcase
            m_ticks = m_ticks + 8'd1;
            if (m_ticks >= len || m_ticks == 8'd0)
            begin
                m_ticks = '0;
                // SDA is sampled at the end of the first SCL-high quarter
                if (m_quarter == 2'd1)
                begin
                    if (m_step == STEP_SEND && m_bit >= BITS_PER_BYTE)
                        m_ack = !it.sda;
                    else if (m_step == STEP_RECV && m_bit < BITS_PER_BYTE)
                        m_shift = {m_shift[6:0], it.sda};
                end
                if (m_quarter != 2'd3)
                    m_quarter = m_quarter + 2'd1;
                else
                begin
                    m_quarter = '0;
                    case (m_step)
                        STEP_START:
                        begin
                            m_step = STEP_SEND;
                            m_bit = '0;
                        end
                        STEP_SEND:
                            if (m_bit < BITS_PER_BYTE)
                                m_bit = m_bit + 4'd1;
                            else if (!m_ack)
                            begin
                                // abort, no STOP
                                if (m_kind == ACT_READ)
                                    m_rx = '0;
                                m_step = STEP_IDLE;
                                r.done = 1'b1;
                            end
                            else if (m_kind == ACT_READ)
                            begin
                                m_step = STEP_RECV;
                                m_bit = '0;
                                m_shift = '0;
                            end
                            else if (m_left != 2'd0)
                            begin
                                m_shift = m_pending[15:8];
                                m_pending = m_pending << 8;
                                m_left = m_left - 2'd1;
                                m_bit = '0;
                            end
                            else
                                m_step = STEP_STOP;
                        STEP_RECV:
                            if (m_bit < BITS_PER_BYTE)
                                m_bit = m_bit + 4'd1;
                            else
                            begin
                                m_rx = m_shift;
                                m_step = STEP_STOP;
                            end
                        default:
                        begin
                            m_step = STEP_IDLE;
                            r.done = 1'b1;
                            r.success = 1'b1;
                        end
                    endcase
                end
            end
        end
        r.scl = m_scl;
        r.sda = m_sda;
        r.busy = (m_step != STEP_IDLE);
        r.read_data = m_rx;
        return r;
    endfunction

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= ACT_TICK;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                bus_levels_due.push_back(next_bus_levels(on_bus));
                ticks_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tick_q.size() != 0 && (no_gaps || $urandom_range(99) >= 8))
                begin
                    on_bus = tick_q.pop_front();
                    s_axis_tdata <= {7'd0, on_bus.sda, on_bus.third, on_bus.second, on_bus.addr};
                    s_axis_tuser <= on_bus.action;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[12:0]);
                results_seen++;
                if (bus_levels_due.size() == 0)
                begin
                    $display("%0t: result item with nothing expected: expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = bus_levels_due.pop_front();
                    check_field("scl_out", 8'(want.scl), 8'(got.scl));
                    check_field("sda_out", 8'(want.sda), 8'(got.sda));
                    check_field("busy_res", 8'(want.busy), 8'(got.busy));
                    check_field("done_res", 8'(want.done), 8'(got.done));
                    check_field("success", 8'(want.success), 8'(got.success));
                    check_field("read_data", want.read_data, got.read_data);
                end
            end
            // one long hold-off early in the run to back the engine up
            if (long_stall != 0)
            begin
                long_stall = long_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!stall_taken && results_seen >= 300)
            begin
                stall_taken = 1'b1;
                long_stall = 400;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= no_gaps || $urandom_range(99) >= 8;
        end
    end

    task automatic queue_idle_ticks(input int n);
        tick_item_t it;
        repeat (n)
        begin
            it.action = ACT_TICK;
            it.addr = 8'($urandom);
            it.second = 8'($urandom);
            it.third = 8'($urandom);
            it.sda = 1'($urandom_range(1));
            tick_q.push_back(it);
        end
    endtask

    // nack_at: index of the byte the slave refuses, past the last byte for none
    task automatic queue_transfer(input act_t kind, input logic [7:0] addr,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input int nack_at, input logic [7:0] rx);
        tick_item_t it;
        int         plan[$];
        int         nbytes;
        int         len;
        int         i;
        int         t;
        bit         aborted;
        bit         first;
        len = (phase_len == 8'd0) ? 1 : phase_len;
        nbytes = (kind == ACT_WRITE3) ? 3 : (kind == ACT_WRITE2) ? 2 : 1;
        aborted = 1'b0;
        plan.push_back(-1);
        for (i = 0; i < nbytes && !aborted; i++)
        begin
            repeat (BITS_PER_BYTE) plan.push_back(-1);
            plan.push_back(i == nack_at ? 1 : 0);
            aborted = (i == nack_at);
        end
        if (!aborted)
        begin
            if (kind == ACT_READ)
            begin
                for (i = BITS_PER_BYTE - 1; i >= 0; i--)
                    plan.push_back(rx[i]);
                plan.push_back(-1);
            end
            plan.push_back(-1);
        end
        if (kind == ACT_READ)
            n_reads++;
        else
            n_writes++;
        if (aborted)
            n_aborts++;
        first = 1'b1;
        foreach (plan[s])
        begin
            for (t = 0; t < 4 * len; t++)
            begin
                it.action = first ? kind : act_t'($urandom_range(3));
                it.addr = first ? addr : 8'($urandom);
                it.second = first ? b2 : 8'($urandom);
                it.third = first ? b3 : 8'($urandom);
                it.sda = (t == 2 * len - 1 && plan[s] >= 0) ? plan[s][0] : 1'($urandom_range(1));
                tick_q.push_back(it);
                first = 1'b0;
            end
        end
    endtask

    task automatic queue_random_transfer();
        act_t kind;
        int   nack;
        kind = act_t'($urandom_range(1, 3));
        nack = 3;
        if ($urandom_range(99) < 20)
            nack = $urandom_range(0, (kind == ACT_WRITE3) ? 2 : (kind == ACT_WRITE2) ? 1 : 0);
        queue_transfer(kind, 8'($urandom), 8'($urandom), 8'($urandom), nack, 8'($urandom));
        queue_idle_ticks($urandom_range(1) ? 0 : $urandom_range(1, 6));
    endtask

    // wait until all items are in and checked, padding ticks until the engine is idle
    task automatic settle();
        forever
        begin
            while (tick_q.size() != 0 || s_axis_tvalid || bus_levels_due.size() != 0)
                @(negedge clk);
            if (m_step == STEP_IDLE)
                break;
            queue_idle_ticks(1);
        end
    endtask

    task automatic write_phase_len(input logic [7:0] value);
        settle();
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        phase_len = value;
        cfg_writes++;
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] phase_lens[3];
        int         p;
        phase_lens = '{8'd1, 8'd2, 8'd1};
        phase_lens[2] = 8'($urandom_range(1, 2));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset phase length, kept to an address NACK
        queue_transfer(ACT_WRITE2, 8'h00, 8'hFF, 8'h00, 0, 8'h00);
        queue_idle_ticks(3);

        // zero length acts as one
        write_phase_len(8'd0);
        queue_transfer(ACT_WRITE3, 8'hFF, 8'hAA, 8'h55, 3, 8'h00);
        queue_idle_ticks(2);
        queue_transfer(ACT_READ, 8'hFF, 8'h00, 8'h00, 3, 8'hA5);
        queue_transfer(ACT_WRITE3, 8'h5A, 8'h01, 8'h80, 1, 8'h00);
        queue_transfer(ACT_READ, 8'h91, 8'h00, 8'h00, 0, 8'hFF);
        queue_idle_ticks(2);

        for (p = 0; p < 3; p++)
        begin
            write_phase_len(phase_lens[p]);
            no_gaps = (p == 1);
            queue_random_transfer();
            settle();
            no_gaps = 1'b0;
        end

        settle();
        repeat (8) @(posedge clk);
        $display("Run covered %0d ticks under %0d phase-length settings", ticks_sent, cfg_writes);
        $display("Transfers: %0d writes, %0d reads, %0d ended by NACK",
                 n_writes, n_reads, n_aborts);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
